// ===== rtl/ubcc_pkg.sv =====
// Shared types, codes and constants for the UART bridge with command capture.
package ubcc_pkg;

    // Default sizes of the stores
    localparam int RING_DEPTH_DEF = 64;
    localparam int CMD_DEPTH_DEF  = 32;

    // Longest run that one command emits
    localparam int MAX_RESULTS = 32;

    // Entries in the queue between front and back
    localparam int Q_DEPTH = 4;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_PREFIX = 1'b0;
    localparam logic REG_TERM   = 1'b1;
    localparam logic [7:0] PREFIX_RESET = 8'h5E;
    localparam logic [7:0] TERM_RESET   = 8'h0D;

    // Input event codes
    localparam logic [1:0] FUNC_HOST_RX   = 2'd0;
    localparam logic [1:0] FUNC_MODULE_RX = 2'd1;
    localparam logic [1:0] FUNC_MODULE_TX = 2'd2;
    localparam logic [1:0] FUNC_HOST_TX   = 2'd3;

    // Result destination codes
    localparam logic [1:0] DEST_MODULE = 2'd0;
    localparam logic [1:0] DEST_HOST   = 2'd1;
    localparam logic [1:0] DEST_CMD    = 2'd2;

    // Operations queued from front to back
    typedef enum logic [1:0] {
        OP_RING_WR = 2'd0,
        OP_DRAIN   = 2'd1,
        OP_CMD     = 2'd2
    } op_kind_t;

    // Back sequencer states
    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DATA = 2'd1,
        BK_SEND = 2'd2
    } back_state_t;

    // Configuration seen by the front
    typedef struct packed {
        logic [7:0] prefix;
        logic [7:0] terminator;
    } cfg_t;

    // Longest run for a given command store depth
    function automatic int emit_max(input int cmd_depth);
        return (cmd_depth - 1 < MAX_RESULTS) ? cmd_depth - 1 : MAX_RESULTS;
    endfunction

    // Width of one queued operation: kind, ring select, ring address, byte,
    // command write flag, command address, emit flag, run length
    function automatic int op_width(input int ring_depth, input int cmd_depth);
        return $clog2(ring_depth) + $clog2(cmd_depth)
             + $clog2(emit_max(cmd_depth) + 1) + 13;
    endfunction

endpackage

// ===== rtl/ubcc_in_if.sv =====
// Input channel: one event item per handshake.
interface ubcc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

// ===== rtl/ubcc_out_if.sv =====
// Output channel: one result item per handshake.
interface ubcc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] dest;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output dest, output out_byte, output last, input ready);
    modport sink   (input valid, input dest, input out_byte, input last, output ready);
endinterface

// ===== rtl/ubcc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ubcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ubcc_fifo.sv =====
// Short register queue that carries operations from front to back.
module ubcc_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = ubcc_pkg::Q_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/ubcc_front.sv =====
// Front: accepts event items, tracks ring indices, flags and capture, and queues work.
module ubcc_front #(
    parameter int RING_DEPTH = ubcc_pkg::RING_DEPTH_DEF,
    parameter int CMD_DEPTH  = ubcc_pkg::CMD_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ubcc_pkg::cfg_t   cfg,
    ubcc_in_if.sink          in_ch,
    input  logic             q_full,
    output logic             q_push,
    output logic [ubcc_pkg::op_width(RING_DEPTH, CMD_DEPTH)-1:0] q_data
);

    localparam int RAW      = $clog2(RING_DEPTH);
    localparam int CAW      = $clog2(CMD_DEPTH);
    localparam int EMIT_MAX = ubcc_pkg::emit_max(CMD_DEPTH);
    localparam int NW       = $clog2(EMIT_MAX + 1);
    localparam logic [RAW-1:0] RING_LAST = RAW'(RING_DEPTH - 1);
    localparam logic [CAW-1:0] CMD_LIM   = CAW'(CMD_DEPTH - 1);
    localparam logic [CAW:0]   EMIT_CAP  = (CAW + 1)'(EMIT_MAX);

    typedef struct packed {
        ubcc_pkg::op_kind_t kind;
        logic               to_host;
        logic [RAW-1:0]     ring_addr;
        logic [7:0]         data;
        logic               cmd_wr;
        logic [CAW-1:0]     cmd_addr;
        logic               emit;
        logic [NW-1:0]      emit_n;
    } op_t;

    logic           link_reg, link_next;
    logic           capture_reg, capture_next;
    logic [CAW-1:0] count_reg, count_next;
    logic [7:0]     byte0_reg, byte0_next;
    logic [7:0]     byte1_reg, byte1_next;
    logic [RAW-1:0] tm_wr_reg, tm_wr_next, tm_rd_reg, tm_rd_next;
    logic [RAW-1:0] th_wr_reg, th_wr_next, th_rd_reg, th_rd_next;
    logic           mod_on_reg, mod_on_next;
    logic           host_on_reg, host_on_next;

    logic           accept;
    logic           stored;
    logic           at_second;
    logic [CAW-1:0] cnt_inc;
    logic [7:0]     b1_now;
    logic [NW-1:0]  run_len;
    op_t            op;

    function automatic logic [RAW-1:0] ring_next(input logic [RAW-1:0] i);
        return (i == RING_LAST) ? '0 : i + 1'b1;
    endfunction

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign q_data      = op;

    // Capture bookkeeping shared by prefix and plain bytes
    assign stored    = (count_reg < CMD_LIM);
    assign at_second = stored && (count_reg == CAW'(1));
    assign cnt_inc   = stored ? count_reg + 1'b1 : count_reg;
    assign b1_now    = at_second ? in_ch.rx_byte : byte1_reg;
    assign run_len   = ({1'b0, cnt_inc} > EMIT_CAP) ? NW'(EMIT_MAX) : NW'(cnt_inc);

    // Classify the item, update state and build the queued operation
    always_comb
    begin
        link_next    = link_reg;
        capture_next = capture_reg;
        count_next   = count_reg;
        byte0_next   = byte0_reg;
        byte1_next   = byte1_reg;
        tm_wr_next   = tm_wr_reg;
        tm_rd_next   = tm_rd_reg;
        th_wr_next   = th_wr_reg;
        th_rd_next   = th_rd_reg;
        mod_on_next  = mod_on_reg;
        host_on_next = host_on_reg;
        q_push       = 1'b0;
        op           = '0;
        op.kind      = ubcc_pkg::OP_CMD;
        op.data      = in_ch.rx_byte;
        op.cmd_addr  = count_reg;
        op.emit_n    = run_len;
        if (accept)
        begin
            unique case (in_ch.func)
                ubcc_pkg::FUNC_HOST_RX:
                begin
                    link_next = 1'b1;
                    if (in_ch.rx_byte == cfg.prefix && !capture_reg)
                    begin
                        // Open a capture with the prefix as first byte
                        capture_next = 1'b1;
                        count_next   = CAW'(1);
                        byte0_next   = in_ch.rx_byte;
                        op.cmd_wr    = 1'b1;
                        op.cmd_addr  = '0;
                        q_push       = 1'b1;
                    end
                    else if (capture_reg)
                    begin
                        // Store while room remains; end on terminator or doubled prefix
                        count_next = cnt_inc;
                        if (at_second)
                        begin
                            byte1_next = in_ch.rx_byte;
                        end
                        op.cmd_wr = stored;
                        if (in_ch.rx_byte == cfg.prefix)
                        begin
                            op.emit = (cnt_inc == CAW'(2)) && (byte0_reg == cfg.prefix)
                                   && (b1_now == cfg.prefix);
                        end
                        else
                        begin
                            op.emit = (in_ch.rx_byte == cfg.terminator);
                        end
                        if (op.emit)
                        begin
                            capture_next = 1'b0;
                        end
                        q_push = stored || op.emit;
                    end
                    else
                    begin
                        op.kind      = ubcc_pkg::OP_RING_WR;
                        op.to_host   = 1'b0;
                        op.ring_addr = tm_wr_reg;
                        tm_wr_next   = ring_next(tm_wr_reg);
                        mod_on_next  = 1'b1;
                        q_push       = 1'b1;
                    end
                end
                ubcc_pkg::FUNC_MODULE_RX:
                begin
                    if (link_reg)
                    begin
                        op.kind      = ubcc_pkg::OP_RING_WR;
                        op.to_host   = 1'b1;
                        op.ring_addr = th_wr_reg;
                        th_wr_next   = ring_next(th_wr_reg);
                        host_on_next = 1'b1;
                        q_push       = 1'b1;
                    end
                end
                ubcc_pkg::FUNC_MODULE_TX:
                begin
                    if (link_reg && mod_on_reg)
                    begin
                        op.kind      = ubcc_pkg::OP_DRAIN;
                        op.to_host   = 1'b0;
                        op.ring_addr = tm_rd_reg;
                        tm_rd_next   = ring_next(tm_rd_reg);
                        if (ring_next(tm_rd_reg) == tm_wr_reg)
                        begin
                            mod_on_next = 1'b0;
                        end
                        q_push = 1'b1;
                    end
                end
                ubcc_pkg::FUNC_HOST_TX:
                begin
                    if (link_reg && host_on_reg)
                    begin
                        op.kind      = ubcc_pkg::OP_DRAIN;
                        op.to_host   = 1'b1;
                        op.ring_addr = th_rd_reg;
                        th_rd_next   = ring_next(th_rd_reg);
                        if (ring_next(th_rd_reg) == th_wr_reg)
                        begin
                            host_on_next = 1'b0;
                        end
                        q_push = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg    <= 1'b0;
            capture_reg <= 1'b0;
            count_reg   <= '0;
            tm_wr_reg   <= '0;
            tm_rd_reg   <= '0;
            th_wr_reg   <= '0;
            th_rd_reg   <= '0;
            mod_on_reg  <= 1'b0;
            host_on_reg <= 1'b0;
        end
        else
        begin
            link_reg    <= link_next;
            capture_reg <= capture_next;
            count_reg   <= count_next;
            tm_wr_reg   <= tm_wr_next;
            tm_rd_reg   <= tm_rd_next;
            th_wr_reg   <= th_wr_next;
            th_rd_reg   <= th_rd_next;
            mod_on_reg  <= mod_on_next;
            host_on_reg <= host_on_next;
        end
    end

    // Copies of the first two stored bytes for the doubled-prefix test
    always_ff @(posedge clk)
    begin
        byte0_reg <= byte0_next;
        byte1_reg <= byte1_next;
    end

endmodule

// ===== rtl/ubcc_back.sv =====
// Back: executes queued operations on the rings and command store and emits result items.
module ubcc_back #(
    parameter int RING_DEPTH = ubcc_pkg::RING_DEPTH_DEF,
    parameter int CMD_DEPTH  = ubcc_pkg::CMD_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  logic [ubcc_pkg::op_width(RING_DEPTH, CMD_DEPTH)-1:0] q_data,
    output logic             q_pop,
    ubcc_out_if.source       out_ch
);

    localparam int RAW      = $clog2(RING_DEPTH);
    localparam int CAW      = $clog2(CMD_DEPTH);
    localparam int EMIT_MAX = ubcc_pkg::emit_max(CMD_DEPTH);
    localparam int NW       = $clog2(EMIT_MAX + 1);

    typedef struct packed {
        ubcc_pkg::op_kind_t kind;
        logic               to_host;
        logic [RAW-1:0]     ring_addr;
        logic [7:0]         data;
        logic               cmd_wr;
        logic [CAW-1:0]     cmd_addr;
        logic               emit;
        logic [NW-1:0]      emit_n;
    } op_t;

    ubcc_pkg::back_state_t state_reg, state_next;

    op_t            head;
    logic           pend_cmd_reg, pend_host_reg;
    logic [CAW-1:0] idx_reg;
    logic [NW-1:0]  n_reg;
    logic [1:0]     dest_reg;
    logic [7:0]     byte_reg;
    logic           last_reg;

    logic           tm_we, th_we, cmd_we;
    logic           tm_re, th_re, cmd_re;
    logic [CAW-1:0] cmd_raddr;
    logic [7:0]     tm_rdata, th_rdata, cmd_rdata;
    logic           starts_read;
    logic           advance;
    logic [CAW:0]   idx_plus;

    assign head        = op_t'(q_data);
    assign starts_read = !q_empty && ((head.kind == ubcc_pkg::OP_DRAIN)
                      || (head.kind == ubcc_pkg::OP_CMD && head.emit));
    assign advance     = out_ch.ready && pend_cmd_reg && !last_reg;
    assign idx_plus    = {1'b0, idx_reg} + 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ubcc_pkg::BK_IDLE:
            begin
                if (starts_read)
                begin
                    state_next = ubcc_pkg::BK_DATA;
                end
            end
            ubcc_pkg::BK_DATA:
            begin
                state_next = ubcc_pkg::BK_SEND;
            end
            ubcc_pkg::BK_SEND:
            begin
                if (out_ch.ready)
                begin
                    state_next = advance ? ubcc_pkg::BK_DATA : ubcc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ubcc_pkg::BK_IDLE;
            end
        endcase
    end

    // Memory strobes and queue pop
    always_comb
    begin
        q_pop     = 1'b0;
        tm_we     = 1'b0;
        th_we     = 1'b0;
        cmd_we    = 1'b0;
        tm_re     = 1'b0;
        th_re     = 1'b0;
        cmd_re    = 1'b0;
        cmd_raddr = '0;
        unique case (state_reg)
            ubcc_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (head.kind)
                        ubcc_pkg::OP_RING_WR:
                        begin
                            tm_we = !head.to_host;
                            th_we = head.to_host;
                        end
                        ubcc_pkg::OP_DRAIN:
                        begin
                            tm_re = !head.to_host;
                            th_re = head.to_host;
                        end
                        ubcc_pkg::OP_CMD:
                        begin
                            cmd_we = head.cmd_wr;
                            cmd_re = head.emit;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ubcc_pkg::BK_SEND:
            begin
                cmd_re    = advance;
                cmd_raddr = idx_plus[CAW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ubcc_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the run context and load the output register
    always_ff @(posedge clk)
    begin
        if (state_reg == ubcc_pkg::BK_IDLE && starts_read)
        begin
            pend_cmd_reg  <= (head.kind == ubcc_pkg::OP_CMD);
            pend_host_reg <= head.to_host;
            n_reg         <= head.emit_n;
            idx_reg       <= '0;
        end
        if (state_reg == ubcc_pkg::BK_SEND && advance)
        begin
            idx_reg <= idx_plus[CAW-1:0];
        end
        if (state_reg == ubcc_pkg::BK_DATA)
        begin
            if (pend_cmd_reg)
            begin
                dest_reg <= ubcc_pkg::DEST_CMD;
                byte_reg <= cmd_rdata;
                last_reg <= (idx_plus == (CAW + 1)'(n_reg));
            end
            else
            begin
                dest_reg <= pend_host_reg ? ubcc_pkg::DEST_HOST : ubcc_pkg::DEST_MODULE;
                byte_reg <= pend_host_reg ? th_rdata : tm_rdata;
                last_reg <= 1'b1;
            end
        end
    end

    assign out_ch.valid    = (state_reg == ubcc_pkg::BK_SEND);
    assign out_ch.dest     = dest_reg;
    assign out_ch.out_byte = byte_reg;
    assign out_ch.last     = last_reg;

    ubcc_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_to_module_ring (
        .clk   (clk),
        .we    (tm_we),
        .waddr (head.ring_addr),
        .wdata (head.data),
        .re    (tm_re),
        .raddr (head.ring_addr),
        .rdata (tm_rdata)
    );

    ubcc_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_to_host_ring (
        .clk   (clk),
        .we    (th_we),
        .waddr (head.ring_addr),
        .wdata (head.data),
        .re    (th_re),
        .raddr (head.ring_addr),
        .rdata (th_rdata)
    );

    ubcc_ram #(.WIDTH(8), .DEPTH(CMD_DEPTH)) u_command_store (
        .clk   (clk),
        .we    (cmd_we),
        .waddr (head.cmd_addr),
        .wdata (head.data),
        .re    (cmd_re),
        .raddr (cmd_raddr),
        .rdata (cmd_rdata)
    );

endmodule

// ===== rtl/uart_bridge_with_command_capture.sv =====
// Top level of the UART bridge with command capture: config registers, front, queue and back.
//
// Each event item is accepted whenever the four-entry operation queue has room; the front
// updates ring indices, send flags and capture state at once and queues the memory work.
// The back retires one ring or command-store write per cycle while it is not busy reading
// out or sending a result. A transmit event's item passes through the registered RAM read
// and then the output register after the back takes it, and each byte of a command run is
// a separate access to the command store's one read port. A run holds at most MAX_RESULTS
// items. There is no clearing pass after reset.
module uart_bridge_with_command_capture #(
    parameter int RING_DEPTH = ubcc_pkg::RING_DEPTH_DEF,
    parameter int CMD_DEPTH  = ubcc_pkg::CMD_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ubcc_pkg::PADDR_W-1:0] paddr,
    input  logic [ubcc_pkg::PDATA_W-1:0] pwdata,
    output logic [ubcc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    ubcc_in_if.sink                      in_ch,
    ubcc_out_if.source                   out_ch
);

    localparam int OP_W = ubcc_pkg::op_width(RING_DEPTH, CMD_DEPTH);

    logic [7:0]     prefix_reg;
    logic [7:0]     term_reg;
    logic           cfg_wr;
    ubcc_pkg::cfg_t cfg;

    logic            q_full, q_empty, q_push, q_pop;
    logic [OP_W-1:0] q_wdata, q_rdata;

    // Register writes on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= ubcc_pkg::PREFIX_RESET;
            term_reg   <= ubcc_pkg::TERM_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == ubcc_pkg::REG_PREFIX)
            begin
                prefix_reg <= pwdata[7:0];
            end
            else
            begin
                term_reg <= pwdata[7:0];
            end
        end
    end

    // Register readback
    assign prdata = {{(ubcc_pkg::PDATA_W - 8){1'b0}},
                     (paddr[2] == ubcc_pkg::REG_TERM) ? term_reg : prefix_reg};

    assign cfg.prefix     = prefix_reg;
    assign cfg.terminator = term_reg;

    ubcc_front #(.RING_DEPTH(RING_DEPTH), .CMD_DEPTH(CMD_DEPTH)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    ubcc_fifo #(.WIDTH(OP_W), .DEPTH(ubcc_pkg::Q_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    ubcc_back #(.RING_DEPTH(RING_DEPTH), .CMD_DEPTH(CMD_DEPTH)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

// ===== rtl/ubcc_checker.sv =====
// Port-level checks for the UART bridge, bound to the top level.
module ubcc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_dest,
    input logic [7:0] out_byte,
    input logic       out_last
);

    // Hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    // Keep the stalled payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_dest) && $stable(out_byte) && $stable(out_last))
        else $error("output payload changed while stalled");

    // Only the three destination codes appear
    a_dest_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_dest == ubcc_pkg::DEST_MODULE) || (out_dest == ubcc_pkg::DEST_HOST)
                      || (out_dest == ubcc_pkg::DEST_CMD))
        else $error("unknown destination code");

    // A transmitted byte is always a run of one
    a_tx_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_dest != ubcc_pkg::DEST_CMD |-> out_last)
        else $error("transmitted byte without last marker");

    // A command run keeps going after a non-final byte
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_dest == ubcc_pkg::DEST_CMD && !out_last
        |-> ##2 out_valid && out_dest == ubcc_pkg::DEST_CMD)
        else $error("command run broken off");

endmodule

bind uart_bridge_with_command_capture ubcc_checker u_ubcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_dest  (out_ch.dest),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last)
);
